### rtl/sdisc_pkg.sv
// Shared types and codes for the one-dimensional star discrepancy block.
// No dependencies; imported by star_discrepancy_1d and its testbench.
package sdisc_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_OVFL  = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_LOAD,
        S_FETCH,
        S_LATCH,
        S_SCAN,
        S_DRAIN,
        S_MUL,
        S_EVAL_LO,
        S_EVAL_HI,
        S_PREP,
        S_DIV,
        S_DONE
    } state_t;

    localparam int unsigned DISC_W   = 17;
    localparam int unsigned SAMPLE_W = 18;

endpackage

### rtl/sdisc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdisc_ram #(
    parameter int unsigned WIDTH = 17,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/star_discrepancy_1d.sv
// Top level of the one-dimensional star discrepancy block.
// Depends on sdisc_pkg and sdisc_ram.
//
// Points stream in one beat per cycle while the block is loading and are
// written to a point RAM; the beat with tlast closes the set. For each
// stored point the block then sweeps the RAM once through its single read
// port, counting points below and not above it, which gives the point's
// rank range in sorted order; one shared multiplier and subtract/compare
// unit scores both ends of that range against the running maximum. A
// restoring divider, one quotient bit a cycle, then forms the result,
// which is handed to the output register; sets with an error skip the
// sweep and the divider. Input is held off during that work and while a
// finished result waits for the output register.
module star_discrepancy_1d
    import sdisc_pkg::*;
#(
    parameter int unsigned MAX_POINTS = 1024,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [17:0] sample, rest zero
    input  logic        s_tlast,   // final_point
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [16:0] discrepancy, [18:17] status, rest zero
);

    localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
    localparam int unsigned AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned XW  = FRAC_BITS + 1;
    localparam int unsigned DW  = CW + 1;
    localparam int unsigned PW  = CW + FRAC_BITS + 2;
    localparam int unsigned NW  = PW + 1;
    localparam int unsigned QCW = $clog2(NW + 1);
    localparam int unsigned EW  = FRAC_BITS + 20;

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             rng_reg, rng_next;
    logic             ovf_reg, ovf_next;
    status_t          st_reg, st_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [CW-1:0]    k_reg, k_next;
    logic [CW-1:0]    lt_reg, lt_next;
    logic [CW-1:0]    le_reg, le_next;
    logic             pend_reg;
    logic [XW-1:0]    xj_reg, xj_next;
    logic [PW-1:0]    prod_reg, prod_next;
    logic [PW-1:0]    worst_reg, worst_next;
    logic [NW-1:0]    num_reg, num_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [QCW-1:0]   qc_reg, qc_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [DISC_W-1:0] m_disc_reg, m_disc_next;
    status_t          m_st_reg, m_st_next;

    logic             ram_we;
    logic [AW-1:0]    ram_raddr;
    logic [XW-1:0]    ram_rdata;
    logic [XW-1:0]    clamp_v;
    logic signed [EW-1:0] s_ext;
    logic             s_neg, s_gt;
    logic             in_beat;
    logic [DW-1:0]    two_n;
    logic [CW-1:0]    rank;
    logic [PW-1:0]    tgt, cand;
    logic [DW:0]      rem_sh, rem_sub;
    logic [NW+DISC_W-1:0] quot_ext;

    // Point store
    sdisc_ram #(
        .WIDTH(XW),
        .DEPTH(MAX_POINTS)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(clamp_v),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Clamp incoming sample to [0, ONE]
    assign s_ext   = {{(EW - SAMPLE_W){s_tdata[SAMPLE_W-1]}}, s_tdata[SAMPLE_W-1:0]};
    assign s_neg   = s_ext[EW-1];
    assign s_gt    = !s_neg && (s_ext > (EW'(1) << FRAC_BITS));
    assign clamp_v = s_neg ? '0 : (s_gt ? (XW'(1) << FRAC_BITS) : s_ext[XW-1:0]);

    assign s_tready = (state_reg == S_LOAD);
    assign in_beat  = s_tvalid && s_tready;
    assign ram_we   = in_beat && (count_reg < CW'(MAX_POINTS));
    assign ram_raddr = (state_reg == S_FETCH) ? j_reg[AW-1:0] : k_reg[AW-1:0];

    // Shared score unit: |2n*x - (2*rank+1)*ONE|
    assign two_n = {count_reg, 1'b0};
    assign rank  = (state_reg == S_EVAL_HI) ? (le_reg - CW'(1)) : lt_reg;
    assign tgt   = PW'({rank, 1'b1}) << FRAC_BITS;
    assign cand  = (prod_reg >= tgt) ? (prod_reg - tgt) : (tgt - prod_reg);

    // Divider step
    assign rem_sh   = {rem_reg, num_reg[NW-1]};
    assign rem_sub  = rem_sh - {1'b0, two_n};
    assign quot_ext = {{DISC_W{1'b0}}, num_reg};

    // Sequencer next state and datapath
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rng_next      = rng_reg;
        ovf_next      = ovf_reg;
        st_next       = st_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        lt_next       = lt_reg;
        le_next       = le_reg;
        xj_next       = xj_reg;
        prod_next     = prod_reg;
        worst_next    = worst_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        qc_next       = qc_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_disc_next   = m_disc_reg;
        m_st_next     = m_st_reg;

        unique case (state_reg)
            S_LOAD: begin
                if (in_beat) begin
                    if (ram_we) begin
                        count_next = count_reg + CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_neg || s_gt) begin
                        rng_next = 1'b1;
                    end
                    if (s_tlast) begin
                        j_next     = '0;
                        worst_next = '0;
                        priority if (ovf_next) begin
                            st_next    = ST_OVFL;
                            state_next = S_DONE;
                        end else if (rng_next) begin
                            st_next    = ST_RANGE;
                            state_next = S_DONE;
                        end else begin
                            st_next    = ST_OK;
                            state_next = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH: begin
                state_next = S_LATCH;
            end
            S_LATCH: begin
                xj_next    = ram_rdata;
                k_next     = '0;
                lt_next    = '0;
                le_next    = '0;
                state_next = S_SCAN;
            end
            S_SCAN, S_DRAIN: begin
                // Count the point returned for the previous address
                if (pend_reg) begin
                    if (ram_rdata < xj_reg) begin
                        lt_next = lt_reg + CW'(1);
                    end
                    if (ram_rdata <= xj_reg) begin
                        le_next = le_reg + CW'(1);
                    end
                end
                if (state_reg == S_SCAN) begin
                    k_next = k_reg + CW'(1);
                    if (k_reg == count_reg - CW'(1)) begin
                        state_next = S_DRAIN;
                    end
                end else begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                prod_next  = PW'(two_n) * PW'(xj_reg);
                state_next = S_EVAL_LO;
            end
            S_EVAL_LO: begin
                if (cand > worst_reg) begin
                    worst_next = cand;
                end
                state_next = S_EVAL_HI;
            end
            S_EVAL_HI: begin
                if (cand > worst_reg) begin
                    worst_next = cand;
                end
                j_next = j_reg + CW'(1);
                if (j_reg == count_reg - CW'(1)) begin
                    state_next = S_PREP;
                end else begin
                    state_next = S_FETCH;
                end
            end
            S_PREP: begin
                num_next   = (NW'(1) << FRAC_BITS) + NW'(worst_reg);
                rem_next   = '0;
                qc_next    = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                // One restoring step per cycle
                if (!rem_sub[DW]) begin
                    rem_next = rem_sub[DW-1:0];
                    num_next = {num_reg[NW-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[DW-1:0];
                    num_next = {num_reg[NW-2:0], 1'b0};
                end
                qc_next = qc_reg + QCW'(1);
                if (qc_reg == QCW'(NW - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // Hand the result to the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_st_next     = st_reg;
                    m_disc_next   = (st_reg == ST_OK) ? quot_ext[DISC_W-1:0] : '0;
                    count_next    = '0;
                    rng_next      = 1'b0;
                    ovf_next      = 1'b0;
                    state_next    = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            rng_reg      <= 1'b0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rng_reg      <= rng_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
            pend_reg     <= (state_reg == S_SCAN);
        end
        st_reg     <= st_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        lt_reg     <= lt_next;
        le_reg     <= le_next;
        xj_reg     <= xj_next;
        prod_reg   <= prod_next;
        worst_reg  <= worst_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        qc_reg     <= qc_next;
        m_disc_reg <= m_disc_next;
        m_st_reg   <= m_st_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_st_reg, m_disc_reg};

`ifndef ASSERT_OFF
    // An error result always carries zero discrepancy
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_st_reg != ST_OK) |-> (m_disc_reg == '0))
        else $error("error result with nonzero discrepancy");

    // The scan address never passes the stored point count
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (k_reg < count_reg))
        else $error("scan address beyond point count");

    // Stored count stays within the store
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond store depth");

    // Every point sits at or below itself, so the upper rank is valid
    a_rank_hi: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVAL_HI) |-> (le_reg != '0) && (le_reg > lt_reg))
        else $error("rank range empty");
`endif

endmodule

### sim/tb_star_discrepancy_1d.sv
// Testbench for star_discrepancy_1d: streams point sets, predicts each result.
// Depends on sdisc_pkg and the star_discrepancy_1d RTL.
module tb_star_discrepancy_1d;
    import sdisc_pkg::*;

    localparam int unsigned NPTS_MAX = 1024;
    localparam longint unsigned ONE_Q = 64'd65536;
    localparam int unsigned IDLE_LIMIT = 2500000;

    typedef struct packed {
        logic [16:0] disc;
        status_t     status;
    } disc_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // predictor state
    longint unsigned pts[NPTS_MAX];
    int unsigned     npts;
    bit              range_bad;
    bit              too_many;
    disc_result_t    expected_q[$];

    int unsigned errors = 0;
    int unsigned idle_cycles = 0;
    bit          stim_done;

    star_discrepancy_1d i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // Sort stored points and form floor((ONE + max |2n*x - (2i+1)ONE|) / 2n)
    function automatic logic [16:0] star_disc(input int unsigned n);
        longint unsigned s[$];
        longint unsigned worst, a, b, d;
        worst = 0;
        for (int i = 0; i < n; i++) s.push_back(pts[i]);
        s.sort();
        for (int i = 0; i < n; i++) begin
            a = 2 * n * s[i];
            b = (2 * i + 1) * ONE_Q;
            d = (a >= b) ? a - b : b - a;
            if (d > worst) worst = d;
        end
        return 17'((ONE_Q + worst) / (2 * n));
    endfunction

    // Update the point set with one accepted beat
    function automatic void predict_point(input logic [17:0] smp, input bit last);
        longint signed sv;
        longint unsigned v;
        disc_result_t r;
        sv = longint'($signed(smp));
        if (sv < 0) begin
            range_bad = 1; v = 0;
        end else if (sv > longint'(ONE_Q)) begin
            range_bad = 1; v = ONE_Q;
        end else begin
            v = longint'(sv);
        end
        if (npts < NPTS_MAX) begin
            pts[npts] = v; npts++;
        end else begin
            too_many = 1;
        end
        if (!last) return;
        r.disc = '0;
        if (too_many) r.status = ST_OVFL;
        else if (range_bad) r.status = ST_RANGE;
        else begin
            r.status = ST_OK;
            r.disc = star_disc(npts);
        end
        expected_q.push_back(r);
        npts = 0; range_bad = 0; too_many = 0;
    endfunction

    // Send one beat, with a random gap between bursts
    int unsigned burst_left;
    task automatic send_point(input logic [17:0] smp, input bit last);
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, smp};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_point(smp, last);
    endtask

    task automatic end_stream();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
    endtask

    function automatic logic [17:0] rand_inrange();
        case ($urandom_range(0, 5))
            0: return 18'd0;
            1: return 18'd65536;
            default: return 18'($urandom_range(0, 65536));
        endcase
    endfunction

    // Receiver stall pattern and result check
    always @(posedge aclk) begin
        disc_result_t got, want;
        if (aresetn) begin
            m_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
            if (m_tvalid && m_tready) begin
                got = {m_tdata[16:0], status_t'(m_tdata[18:17])};
                if (expected_q.size() == 0) begin
                    report_mismatch("result with none expected");
                end else begin
                    want = expected_q.pop_front();
                    if (got.disc !== want.disc)
                        report_mismatch($sformatf("discrepancy %0d want %0d",
                                                  got.disc, want.disc));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d want %0d",
                                                  got.status, want.status));
                    if (m_tdata[23:19] !== '0) report_mismatch("pad bits set");
                end
            end
        end
    end

    // Watchdog on cycles with no beat accepted
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("[star_discrepancy_1d] ERROR");
            $finish;
        end
    end

    // Single points, extremes, duplicates and unsorted sets
    task automatic test_directed();
        send_point(18'd0, 1);
        send_point(18'd65536, 1);
        send_point(18'd32768, 1);
        send_point(18'd65536, 0); send_point(18'd0, 0); send_point(18'd1, 1);
        send_point(18'd100, 0); send_point(18'd100, 0); send_point(18'd100, 1);
        send_point(18'd5000, 0); send_point(18'd40000, 0); send_point(18'd20000, 0);
        send_point(18'd60000, 1);
    endtask

    // Out-of-range samples: negative, above one, all bits
    task automatic test_range_errors();
        send_point(18'h20000, 1);
        send_point(18'h3FFFF, 0); send_point(18'd100, 1);
        send_point(18'd65537, 1);
        send_point(18'h1FFFF, 0); send_point(18'd0, 1);
        send_point(18'd300, 0); send_point(18'h2AAAA, 1);
        send_point(18'h15555, 1);
    endtask

    // One point past the store size, with a range error in the same set
    task automatic test_overflow();
        for (int i = 0; i < NPTS_MAX + 1; i++)
            send_point(i == 5 ? 18'h3FFF0 : rand_inrange(), i == NPTS_MAX);
    endtask

    // Random sets, mostly small and well formed
    task automatic test_random();
        int unsigned sent, n;
        sent = 0;
        while (sent < 700) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 14) == 0) send_point(18'($urandom), i == n - 1);
                else send_point(rand_inrange(), i == n - 1);
            end
            sent += n;
        end
    endtask

    initial begin
        npts = 0; range_bad = 0; too_many = 0;
        burst_left = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_range_errors();
        test_random();
        test_overflow();
        end_stream();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("[star_discrepancy_1d] OK");
        end else begin
            $display("[star_discrepancy_1d] ERROR");
        end
        $finish;
    end

endmodule
